### hdl/prk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prk_pkg
// shared constants, types and table helpers for the park rotation block
// ----------------------------------------------------------------------------
package prk_pkg;

    localparam int DEF_DATA_BITS  = 16;
    localparam int DEF_ANGLE_BITS = 12;

    // table entries hold round(SINE_SCALE * sin) as unsigned magnitudes
    localparam int TABLE_BITS = 16;
    localparam int SINE_SCALE = 32767;
    localparam int FRAC_BITS  = 15;
    localparam int ROUND_BIAS = 1 << (FRAC_BITS - 1);

    localparam real HALF_PI = 1.5707963267948966;

    typedef struct packed {
        logic valid;
        logic action;
        logic sin_neg;
        logic cos_neg;
    } prk_ctrl_t;

    // one quarter-wave entry, step is the phase increment per entry in radians
    function automatic logic [TABLE_BITS-1:0] sine_entry(int k, real step);
        real ph;
        real v;
        ph = step * real'(k);
        v  = $floor(real'(SINE_SCALE) * $sin(ph) + 0.5);
        return TABLE_BITS'($rtoi(v));
    endfunction

endpackage

### hdl/park_rotation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// park_rotation
// forward and inverse park rotation of a fixed-point vector by a turn angle
// ----------------------------------------------------------------------------
//  channel   handshake       payload
//  input     start / busy    action, first_in, second_in, angle
//  result    done strobe     first_out, second_out, saturated
//
//  one transaction per cycle; busy is held low, nothing stalls the pipe
//  the pipe runs sine table read, multiplier stage, then round/saturate, each registered
//  the rate is set by the two-port quarter-wave table, read once per transaction
//  reset clears only the valid pipeline and the first control register; the table is constant
//  done is high for one cycle per transaction, the receiver cannot stall it
// ----------------------------------------------------------------------------
module park_rotation #(
    parameter int DATA_BITS  = prk_pkg::DEF_DATA_BITS,
    parameter int ANGLE_BITS = prk_pkg::DEF_ANGLE_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         action,
    input  logic signed [DATA_BITS-1:0]  first_in,
    input  logic signed [DATA_BITS-1:0]  second_in,
    input  logic [ANGLE_BITS-1:0]        angle,
    output logic                         done,
    output logic signed [DATA_BITS-1:0]  first_out,
    output logic signed [DATA_BITS-1:0]  second_out,
    output logic                         saturated
);
    import prk_pkg::*;

    localparam int QSHIFT = ANGLE_BITS - 2;
    localparam int AW     = QSHIFT + 1;
    localparam logic [AW-1:0]         QUARTER  = AW'(1) << QSHIFT;
    localparam logic [ANGLE_BITS-1:0] QUARTERA = ANGLE_BITS'(1) << QSHIFT;

    // fold a full-turn angle onto the quarter-wave table
    function automatic logic [AW-1:0] fold(logic [ANGLE_BITS-1:0] a);
        logic [AW-1:0] r;
        r = {1'b0, a[QSHIFT-1:0]};
        return a[QSHIFT] ? (QUARTER - r) : r;
    endfunction

    logic [ANGLE_BITS-1:0] cos_angle;
    logic [AW-1:0]         sin_addr, cos_addr;
    logic                  accept;
    prk_ctrl_t             ctrl_next, ctrl_reg;
    logic signed [DATA_BITS-1:0] x_reg, y_reg;
    logic [TABLE_BITS-1:0] sin_mag, cos_mag;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    always_comb
    begin
        cos_angle         = angle + QUARTERA;
        sin_addr          = fold(angle);
        cos_addr          = fold(cos_angle);
        ctrl_next.valid   = accept;
        ctrl_next.action  = action;
        ctrl_next.sin_neg = angle[ANGLE_BITS-1];
        ctrl_next.cos_neg = cos_angle[ANGLE_BITS-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= first_in;
        y_reg <= second_in;
    end

    prk_sine_rom #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_rom (
        .clk    (clk),
        .addr_a (sin_addr),
        .addr_b (cos_addr),
        .data_a (sin_mag),
        .data_b (cos_mag)
    );

    prk_rotate #(
        .DATA_BITS (DATA_BITS)
    ) u_rotate (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl_reg),
        .x_in       (x_reg),
        .y_in       (y_reg),
        .sin_mag    (sin_mag),
        .cos_mag    (cos_mag),
        .done       (done),
        .first_out  (first_out),
        .second_out (second_out),
        .saturated  (saturated)
    );

endmodule

### hdl/prk_sine_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prk_sine_rom
// quarter-wave sine table, two synchronous read ports with registered outputs
// ----------------------------------------------------------------------------
module prk_sine_rom #(
    parameter int ANGLE_BITS = prk_pkg::DEF_ANGLE_BITS
) (
    input  logic                            clk,
    input  logic [ANGLE_BITS-2:0]           addr_a,
    input  logic [ANGLE_BITS-2:0]           addr_b,
    output logic [prk_pkg::TABLE_BITS-1:0]  data_a,
    output logic [prk_pkg::TABLE_BITS-1:0]  data_b
);
    import prk_pkg::*;

    localparam int  QSHIFT = ANGLE_BITS - 2;
    localparam int  DEPTH  = (1 << QSHIFT) + 1;
    localparam real STEP   = HALF_PI / real'(1 << QSHIFT);

    typedef logic [TABLE_BITS-1:0] rom_t [DEPTH];

    function automatic rom_t build_rom();
        rom_t t;
        for (int k = 0; k < DEPTH; k++)
        begin
            t[k] = sine_entry(k, STEP);
        end
        return t;
    endfunction

    localparam rom_t ROM = build_rom();

    logic [TABLE_BITS-1:0] data_a_reg;
    logic [TABLE_BITS-1:0] data_b_reg;

    always_ff @(posedge clk)
    begin
        data_a_reg <= ROM[addr_a];
        data_b_reg <= ROM[addr_b];
    end

    assign data_a = data_a_reg;
    assign data_b = data_b_reg;

endmodule

### hdl/prk_rotate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prk_rotate
// signs the table values, forms the four products, then sums, rounds and
// saturates into the result registers
// ----------------------------------------------------------------------------
module prk_rotate #(
    parameter int DATA_BITS = prk_pkg::DEF_DATA_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  prk_pkg::prk_ctrl_t              ctrl,
    input  logic signed [DATA_BITS-1:0]     x_in,
    input  logic signed [DATA_BITS-1:0]     y_in,
    input  logic [prk_pkg::TABLE_BITS-1:0]  sin_mag,
    input  logic [prk_pkg::TABLE_BITS-1:0]  cos_mag,
    output logic                            done,
    output logic signed [DATA_BITS-1:0]     first_out,
    output logic signed [DATA_BITS-1:0]     second_out,
    output logic                            saturated
);
    import prk_pkg::*;

    localparam int PW = DATA_BITS + TABLE_BITS;
    localparam int SW = PW + 1;
    localparam int RW = SW - FRAC_BITS;
    localparam logic signed [RW-1:0] MAXV = RW'((2 ** (DATA_BITS - 1)) - 1);
    localparam logic signed [RW-1:0] MINV = -MAXV - RW'(1);

    // clip to range, flag in the top bit
    function automatic logic [DATA_BITS:0] clip(logic signed [RW-1:0] v);
        logic [DATA_BITS:0] r;
        if (v > MAXV)
        begin
            r = {1'b1, MAXV[DATA_BITS-1:0]};
        end
        else if (v < MINV)
        begin
            r = {1'b1, MINV[DATA_BITS-1:0]};
        end
        else
        begin
            r = {1'b0, v[DATA_BITS-1:0]};
        end
        return r;
    endfunction

    logic signed [TABLE_BITS-1:0] sin_val;
    logic signed [TABLE_BITS-1:0] cos_val;
    logic signed [PW-1:0]         xc_next, ys_next, xs_next, yc_next;
    logic signed [PW-1:0]         xc_reg, ys_reg, xs_reg, yc_reg;
    logic                         valid2_reg;
    logic                         action2_reg;

    always_comb
    begin
        sin_val = ctrl.sin_neg ? -$signed(sin_mag) : $signed(sin_mag);
        cos_val = ctrl.cos_neg ? -$signed(cos_mag) : $signed(cos_mag);
        xc_next = PW'(x_in * cos_val);
        ys_next = PW'(y_in * sin_val);
        xs_next = PW'(x_in * sin_val);
        yc_next = PW'(y_in * cos_val);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid2_reg <= 1'b0;
        end
        else
        begin
            valid2_reg <= ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        action2_reg <= ctrl.action;
        xc_reg      <= xc_next;
        ys_reg      <= ys_next;
        xs_reg      <= xs_next;
        yc_reg      <= yc_next;
    end

    logic signed [SW-1:0]  f_sum, g_sum;
    logic signed [RW-1:0]  f_rnd, g_rnd;
    logic [DATA_BITS:0]    f_clip, g_clip;

    always_comb
    begin
        if (action2_reg)
        begin
            f_sum = SW'(xc_reg) + SW'(ys_reg);
            g_sum = SW'(yc_reg) - SW'(xs_reg);
        end
        else
        begin
            f_sum = SW'(xc_reg) - SW'(ys_reg);
            g_sum = SW'(xs_reg) + SW'(yc_reg);
        end
        f_rnd  = RW'((f_sum + SW'(ROUND_BIAS)) >>> FRAC_BITS);
        g_rnd  = RW'((g_sum + SW'(ROUND_BIAS)) >>> FRAC_BITS);
        f_clip = clip(f_rnd);
        g_clip = clip(g_rnd);
    end

    logic                        done_reg;
    logic signed [DATA_BITS-1:0] first_reg, second_reg;
    logic                        sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg  <= f_clip[DATA_BITS-1:0];
        second_reg <= g_clip[DATA_BITS-1:0];
        sat_reg    <= f_clip[DATA_BITS] | g_clip[DATA_BITS];
    end

    assign done       = done_reg;
    assign first_out  = first_reg;
    assign second_out = second_reg;
    assign saturated  = sat_reg;

endmodule
